// File: rtl/ppo_pkg.sv
// Shared types and constants of the payload pattern overwrite unit.
// Used by every module under rtl; depends on nothing else.
package ppo_pkg;

	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 64;
	localparam int LEN_W     = 4;
	localparam int COUNT_W   = 16;
	localparam int RPOS_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_W   = 32;
	localparam int TUSER_W   = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MATCH_BYTES    = 2'd0,
		CFG_MATCH_LENGTH   = 2'd1,
		CFG_REPLACE_BYTES  = 2'd2,
		CFG_REPLACE_LENGTH = 2'd3
	} cfg_reg_t;

	// Per-cell control: shift toward the head, or load the incoming byte.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	// One result item on its way to the output port.
	typedef struct packed {
		logic               any_rewrite;
		logic [COUNT_W-1:0] count;
		logic               last;
		logic               rewritten;
		logic [BYTE_W-1:0]  data;
	} out_item_t;

	function automatic logic [BYTE_W-1:0] byte_of(input logic [CFG_W-1:0] word,
			input logic [RPOS_W-1:0] k);
		byte_of = word[k*BYTE_W +: BYTE_W];
	endfunction

endpackage

// File: rtl/ppo_cell.sv
// One cell of the lookahead window: holds a byte and compares it with its
// match-string byte. Depends on ppo_pkg.
module ppo_cell (
	input  logic                          clk,
	input  ppo_pkg::cell_ctrl_t           ctrl,
	input  logic [ppo_pkg::BYTE_W-1:0]    in_byte,
	input  logic [ppo_pkg::BYTE_W-1:0]    next_byte,
	input  logic [ppo_pkg::BYTE_W-1:0]    pat_byte,
	output logic [ppo_pkg::BYTE_W-1:0]    cell_byte,
	output logic                          eq
);

	logic [ppo_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= in_byte;
		end else if (ctrl.shift) begin
			byte_q <= next_byte;
		end
	end

	assign cell_byte = byte_q;
	assign eq        = (byte_q == pat_byte);

endmodule

// File: rtl/ppo_out_buf.sv
// Two-entry output buffer that decouples the window engine from the
// master stream. Depends on ppo_pkg.
module ppo_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ppo_pkg::out_item_t    item,
	output logic                  space,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ppo_pkg::out_item_t    out_item
);

	ppo_pkg::out_item_t entry0_q;
	ppo_pkg::out_item_t entry1_q;
	logic [1:0]         cnt_q;
	logic               pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = entry0_q;
	assign space     = (cnt_q != 2'd2);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (!push && pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			// Push only happens with room, so the buffer held one item.
			entry0_q <= item;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				entry0_q <= item;
			end else begin
				entry1_q <= item;
			end
		end else if (pop) begin
			entry0_q <= entry1_q;
		end
	end

endmodule

// File: rtl/payload_pattern_overwrite_unit.sv
// Payload pattern overwrite unit: bytes stream in on the slave side and leave
// on the master side in the same order, with every non-overlapping hit of the
// match string (scanned left to right on original bytes) overwritten by the
// replacement string. The window is a row of MAX_PATTERN_BYTES cells that
// shift toward the head; one byte is decided per cycle while the output buffer
// has space, and a hit emits its first replacement byte in the same cycle, so
// the unit takes and gives one item per cycle in steady state. A byte leaves
// once max(match_length, replace_length) bytes are held; after the final byte
// of a payload the held bytes drain at one per cycle, as buffer space allows,
// while input is held off. The last item of a payload carries the saturating
// count of rewritten bytes. An input item waits in the window until enough
// bytes are held, then passes through the output buffer. Configuration must
// be written only between items; the unit itself does not enforce this.
module payload_pattern_overwrite_unit #(
	parameter int MAX_PATTERN_BYTES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ppo_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppo_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ppo_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] in_byte
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [7:0] out_byte, [23:8] rewritten_count, [24] any_rewrite, rest zero
	output logic [ppo_pkg::TDATA_W-1:0]        m_axis_tdata,
	output logic [ppo_pkg::TUSER_W-1:0]        m_axis_tuser,   // [0] out_rewritten
	output logic                               m_axis_tlast
);

	localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int BW     = ppo_pkg::BYTE_W;
	localparam int LW     = ppo_pkg::LEN_W;
	localparam int CW     = ppo_pkg::COUNT_W;
	localparam int RW     = ppo_pkg::RPOS_W;

	// Configuration registers.
	logic [ppo_pkg::CFG_W-1:0] match_bytes_q;
	logic [LW-1:0]             match_length_q;
	logic [ppo_pkg::CFG_W-1:0] replace_bytes_q;
	logic [LW-1:0]             replace_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_bytes_q    <= '0;
			match_length_q   <= LW'(1);
			replace_bytes_q  <= '0;
			replace_length_q <= LW'(1);
		end else if (cfg_we) begin
			unique case (ppo_pkg::cfg_reg_t'(cfg_index))
				ppo_pkg::CFG_MATCH_BYTES:    match_bytes_q    <= cfg_data;
				ppo_pkg::CFG_MATCH_LENGTH:   match_length_q   <= cfg_data[LW-1:0];
				ppo_pkg::CFG_REPLACE_BYTES:  replace_bytes_q  <= cfg_data;
				ppo_pkg::CFG_REPLACE_LENGTH: replace_length_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// Scan state.
	logic [FILL_W-1:0] fill_q;
	logic [LW-1:0]     ow_rem_q;
	logic [RW-1:0]     rpos_q;
	logic [CW-1:0]     total_q;
	logic              last_q;

	logic [LW-1:0] ml, rl, need, fill_ext, hit_len;
	logic          space, decide_ok, head_hit, emit, accept, final_emit;
	logic [FILL_W-1:0] load_idx;
	logic [CW:0]       sum;
	logic [CW-1:0]     total_next;
	ppo_pkg::out_item_t item, out_item;

	logic [BW-1:0]                cell_byte [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] cell_eq;
	logic [MAX_PATTERN_BYTES-1:0] cmp_ok;

	// Lengths of zero count as one, lengths beyond the window as the window.
	always_comb begin
		ml = match_length_q;
		if (match_length_q == '0) begin
			ml = LW'(1);
		end else if (match_length_q > LW'(MAX_PATTERN_BYTES)) begin
			ml = LW'(MAX_PATTERN_BYTES);
		end
		rl = replace_length_q;
		if (replace_length_q == '0) begin
			rl = LW'(1);
		end else if (replace_length_q > LW'(MAX_PATTERN_BYTES)) begin
			rl = LW'(MAX_PATTERN_BYTES);
		end
		need = (ml > rl) ? ml : rl;
	end

	assign fill_ext  = LW'(fill_q);
	assign decide_ok = last_q || (fill_ext >= need);
	assign head_hit  = (fill_ext >= ml) && (&cmp_ok);
	assign hit_len   = (fill_ext < rl) ? ml : rl;

	assign emit          = space && (fill_q != '0) && ((ow_rem_q != '0) || decide_ok);
	assign final_emit    = emit && last_q && (fill_q == FILL_W'(1));
	assign s_axis_tready = !last_q && ((fill_q < FILL_W'(MAX_PATTERN_BYTES)) || emit);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign load_idx      = fill_q - FILL_W'(emit);

	// A hit adds its length to the saturating total in the cycle it is found.
	always_comb begin
		sum = {1'b0, total_q} + (CW+1)'(hit_len);
		total_next = total_q;
		if (emit && (ow_rem_q == '0) && head_hit) begin
			total_next = sum[CW] ? ppo_pkg::COUNT_MAX : sum[CW-1:0];
		end
	end

	always_comb begin
		item = '0;
		if (ow_rem_q != '0) begin
			item.data      = ppo_pkg::byte_of(replace_bytes_q, rpos_q);
			item.rewritten = 1'b1;
		end else if (head_hit) begin
			item.data      = ppo_pkg::byte_of(replace_bytes_q, '0);
			item.rewritten = 1'b1;
		end else begin
			item.data      = cell_byte[0];
			item.rewritten = 1'b0;
		end
		if (final_emit) begin
			item.last        = 1'b1;
			item.count       = total_next;
			item.any_rewrite = (total_next != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ow_rem_q <= '0;
			rpos_q   <= '0;
			total_q  <= '0;
			last_q   <= 1'b0;
		end else if (final_emit) begin
			fill_q   <= '0;
			ow_rem_q <= '0;
			rpos_q   <= '0;
			total_q  <= '0;
			last_q   <= 1'b0;
		end else begin
			fill_q  <= load_idx + FILL_W'(accept);
			total_q <= total_next;
			if (accept && s_axis_tlast) begin
				last_q <= 1'b1;
			end
			if (emit) begin
				if (ow_rem_q != '0) begin
					ow_rem_q <= ow_rem_q - LW'(1);
					rpos_q   <= rpos_q + RW'(1);
				end else if (head_hit) begin
					ow_rem_q <= hit_len - LW'(1);
					rpos_q   <= RW'(1);
				end
			end
		end
	end

	// Row of window cells; cell 0 holds the oldest byte.
	for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
		ppo_pkg::cell_ctrl_t ctrl;
		logic [BW-1:0]       next_byte;

		assign ctrl.shift = emit;
		assign ctrl.load  = accept && (load_idx == FILL_W'(i));
		if (i == MAX_PATTERN_BYTES - 1) begin : g_tail
			assign next_byte = '0;
		end else begin : g_mid
			assign next_byte = cell_byte[i+1];
		end
		// Cells beyond the match length do not take part in the compare.
		assign cmp_ok[i] = cell_eq[i] || (LW'(i) >= ml);

		ppo_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.in_byte   (s_axis_tdata),
			.next_byte (next_byte),
			.pat_byte  (match_bytes_q[i*BW +: BW]),
			.cell_byte (cell_byte[i]),
			.eq        (cell_eq[i])
		);
	end

	ppo_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.item      (item),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = ppo_pkg::TDATA_W'({out_item.any_rewrite, out_item.count,
		out_item.data});
	assign m_axis_tuser = ppo_pkg::TUSER_W'(out_item.rewritten);
	assign m_axis_tlast = out_item.last;

endmodule

// File: rtl/ppo_checker.sv
// Port-level checks of the payload pattern overwrite unit, bound to the top.
// Depends on ppo_pkg and payload_pattern_overwrite_unit.
module ppo_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic                               s_axis_tlast,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [ppo_pkg::TDATA_W-1:0]        m_axis_tdata,
	input  logic [ppo_pkg::TUSER_W-1:0]        m_axis_tuser,
	input  logic                               m_axis_tlast
);

	// A stalled output item stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("output item changed while stalled");

	// Summary fields are zero on every item but the last of a payload.
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[24:8] == '0)
		else $error("summary fields set before end of payload");

	// The flag and the count agree at the end of a payload.
	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[24] == (m_axis_tdata[23:8] != '0))
		else $error("any_rewrite disagrees with rewritten_count");

	// A rewritten final byte must have been counted.
	a_last_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tuser[0] |-> m_axis_tdata[23:8] != '0)
		else $error("rewritten final byte not counted");

	// After the final byte of a payload the unit drains before taking more.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after the final byte");

endmodule

bind payload_pattern_overwrite_unit ppo_checker u_ppo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of payload_pattern_overwrite_unit: directed and random payloads
// are predicted by an in-bench window model and compared byte for byte at the output.
// Depends on rtl/ppo_pkg.sv and rtl/payload_pattern_overwrite_unit.sv.
module tb;

	localparam int BYTE_W    = ppo_pkg::BYTE_W;
	localparam int CFG_W     = ppo_pkg::CFG_W;
	localparam int LEN_W     = ppo_pkg::LEN_W;
	localparam int COUNT_W   = ppo_pkg::COUNT_W;
	localparam int CFG_IDX_W = ppo_pkg::CFG_IDX_W;
	localparam int TDATA_W   = ppo_pkg::TDATA_W;
	localparam int TUSER_W   = ppo_pkg::TUSER_W;
	localparam int COUNT_MAX = int'(ppo_pkg::COUNT_MAX);

	localparam int WINDOW = 8;
	// The window depth plus the output buffer, with some margin.
	localparam int SETTLE_CYCLES = WINDOW + 6;

	typedef logic [BYTE_W-1:0] payload_t[$];

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata = '0;   // [7:0] in_byte
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]   m_axis_tdata;        // [7:0] out_byte, [23:8] count, [24] any
	logic [TUSER_W-1:0]   m_axis_tuser;        // [0] out_rewritten
	logic                 m_axis_tlast;

	// Register copies and window state of the prediction.
	logic [CFG_W-1:0]  match_str = '0;
	logic [CFG_W-1:0]  replace_str = '0;
	logic [LEN_W-1:0]  match_len = 4'd1;
	logic [LEN_W-1:0]  replace_len = 4'd1;
	logic [BYTE_W-1:0] held [WINDOW] = '{default: '0};
	int held_count = 0;
	int overwrite_left = 0;
	int replace_pos = 0;
	int rewrite_sum = 0;

	ppo_pkg::out_item_t expected_bytes[$];
	bit no_gaps = 1'b0;
	int errors = 0;
	int items_sent = 0;
	int bytes_checked = 0;
	int bytes_rewritten = 0;
	int settings_used = 0;

	payload_pattern_overwrite_unit #(
		.MAX_PATTERN_BYTES(WINDOW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 25);
	end

	function automatic int clamp_length(input logic [LEN_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > WINDOW)
			return WINDOW;
		return v;
	endfunction

	function automatic void drop_oldest();
		for (int k = 0; k < WINDOW - 1; k++)
			held[k] = held[k + 1];
		held[WINDOW - 1] = '0;
		held_count--;
	endfunction

	// Works out the output bytes that one accepted input byte releases.
	task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
		int ml;
		int rl;
		int need;
		int n;
		bit hit;
		ppo_pkg::out_item_t burst [WINDOW];
		ml = clamp_length(match_len);
		rl = clamp_length(replace_len);
		need = (ml > rl) ? ml : rl;
		n = 0;
		if (held_count < WINDOW) begin
			held[held_count] = b;
			held_count++;
		end
		while (held_count > 0 && n < WINDOW) begin
			if (overwrite_left > 0) begin
				burst[n] = '0;
				burst[n].data = replace_str[replace_pos*BYTE_W +: BYTE_W];
				burst[n].rewritten = 1'b1;
				n++;
				drop_oldest();
				overwrite_left--;
				replace_pos = (replace_pos + 1) % WINDOW;
			end else if (!last && held_count < need) begin
				break;
			end else begin
				// Matching always looks at original bytes held in the window.
				hit = (held_count >= ml);
				for (int k = 0; k < ml; k++)
					if (held[k] != match_str[k*BYTE_W +: BYTE_W])
						hit = 1'b0;
				if (hit) begin
					overwrite_left = (held_count < rl) ? ml : rl;
					replace_pos = 0;
					rewrite_sum += overwrite_left;
					if (rewrite_sum > COUNT_MAX)
						rewrite_sum = COUNT_MAX;
				end else begin
					burst[n] = '0;
					burst[n].data = held[0];
					n++;
					drop_oldest();
				end
			end
		end
		if (last) begin
			if (n > 0) begin
				burst[n - 1].last = 1'b1;
				burst[n - 1].count = rewrite_sum[COUNT_W-1:0];
				burst[n - 1].any_rewrite = (rewrite_sum > 0);
			end
			for (int k = 0; k < WINDOW; k++)
				held[k] = '0;
			held_count = 0;
			overwrite_left = 0;
			replace_pos = 0;
			rewrite_sum = 0;
		end
		for (int k = 0; k < n; k++)
			expected_bytes.push_back(burst[k]);
	endtask

	task automatic check_field(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		ppo_pkg::out_item_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			bytes_checked++;
			if (m_axis_tuser[0])
				bytes_rewritten++;
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected output item, expected none, got tdata %08h",
					$time, m_axis_tdata);
			end else begin
				want = expected_bytes.pop_front();
				check_field("out_byte", want.data, m_axis_tdata[BYTE_W-1:0]);
				check_field("rewritten_count", want.count, m_axis_tdata[BYTE_W +: COUNT_W]);
				check_field("any_rewrite", want.any_rewrite, m_axis_tdata[BYTE_W + COUNT_W]);
				check_field("tdata padding", 0, m_axis_tdata[TDATA_W-1:BYTE_W + COUNT_W + 1]);
				check_field("out_rewritten", want.rewritten, m_axis_tuser[0]);
				check_field("out_last", want.last, m_axis_tlast);
			end
		end
	end

	task automatic send_item(input logic [BYTE_W-1:0] b, input logic last);
		if (!no_gaps && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_byte(b, last);
		items_sent++;
	endtask

	// Holds off input until every predicted item has left and the block is quiet.
	task automatic drain_and_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input ppo_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			ppo_pkg::CFG_MATCH_BYTES: match_str = value;
			ppo_pkg::CFG_MATCH_LENGTH: match_len = value[LEN_W-1:0];
			ppo_pkg::CFG_REPLACE_BYTES: replace_str = value;
			ppo_pkg::CFG_REPLACE_LENGTH: replace_len = value[LEN_W-1:0];
		endcase
	endtask

	task automatic configure(input logic [CFG_W-1:0] m, input logic [LEN_W-1:0] ml,
			input logic [CFG_W-1:0] r, input logic [LEN_W-1:0] rl);
		write_reg(ppo_pkg::CFG_MATCH_BYTES, m);
		write_reg(ppo_pkg::CFG_MATCH_LENGTH, CFG_W'(ml));
		write_reg(ppo_pkg::CFG_REPLACE_BYTES, r);
		write_reg(ppo_pkg::CFG_REPLACE_LENGTH, CFG_W'(rl));
		settings_used++;
	endtask

	task automatic send_payload(input payload_t p, input int pause_at);
		foreach (p[i]) begin
			if (i == pause_at)
				drain_and_idle();
			send_item(p[i], i == p.size() - 1);
		end
	endtask

	// Reset registers: single zero byte replaced by a zero byte.
	task automatic test_reset_defaults();
		send_payload('{8'h00, 8'h7E, 8'h00, 8'hFF}, -1);
		drain_and_idle();
	endtask

	// Overlapping candidates, a hit too close to the end for the full replacement,
	// and a payload shorter than the match string.
	task automatic test_tail_hits();
		configure(64'hA5A5_A5A5_A5A5_4241, 4'd2, 64'hFFFF_FFFF_FF7A_7978, 4'd3);
		send_payload('{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42}, -1);
		send_payload('{8'h41}, -1);
		drain_and_idle();
	endtask

	// Widest match with the shortest replacement, then lengths out of range.
	task automatic test_length_extremes();
		configure('1, 4'd8, '0, 4'd1);
		send_payload('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, -1);
		drain_and_idle();
		configure('0, 4'd0, '1, 4'd15);
		send_payload('{8'h00, 8'h00}, -1);
		drain_and_idle();
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? LEN_W'($urandom_range(9, 15)) : '0;
		return LEN_W'($urandom_range(1, 8));
	endfunction

	// Payloads built mostly from copies and broken prefixes of the match string.
	task automatic test_random_payloads(input int item_goal);
		int start_items;
		int phase;
		int n;
		int ml;
		int r;
		int cut;
		bit noise;
		payload_t p;
		start_items = items_sent;
		phase = 0;
		while (items_sent - start_items < item_goal) begin
			// The second and third settings run with both sides streaming without gaps.
			no_gaps = (phase == 1) || (phase == 2);
			configure({$urandom, $urandom}, pick_length(), {$urandom, $urandom}, pick_length());
			ml = clamp_length(match_len);
			for (int j = $urandom_range(2, 4); j > 0; j--) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
				if (phase == 0 && j == 1)
					n = $urandom_range(6, 10);
				noise = ($urandom_range(0, 9) == 0);
				p = {};
				while (p.size() < n) begin
					r = $urandom_range(0, 99);
					if (!noise && r < 45) begin
						for (int k = 0; k < ml; k++)
							p.push_back(match_str[k*BYTE_W +: BYTE_W]);
					end else if (!noise && r < 65) begin
						cut = $urandom_range(0, ml - 1);
						for (int k = 0; k < cut; k++)
							p.push_back(match_str[k*BYTE_W +: BYTE_W]);
						p.push_back(BYTE_W'($urandom_range(0, 255)));
					end else begin
						p.push_back(BYTE_W'($urandom_range(0, 255)));
					end
				end
				while (p.size() > n)
					void'(p.pop_back());
				// The last payload of the first setting stalls after its third byte, with any undecided bytes held.
				send_payload(p, (phase == 0 && j == 1) ? 3 : -1);
			end
			drain_and_idle();
			phase++;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_tail_hits();
		test_length_extremes();
		test_random_payloads(90);
		drain_and_idle();
		$display("Sent %0d input items under %0d register settings, with clamped lengths,",
			items_sent, settings_used);
		$display("gap-free stretches and a mid-payload drain; %0d output items checked, %0d rewritten.",
			bytes_checked, bytes_rewritten);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: payload_pattern_overwrite_unit.f
rtl/ppo_pkg.sv
rtl/ppo_cell.sv
rtl/ppo_out_buf.sv
rtl/payload_pattern_overwrite_unit.sv
rtl/ppo_checker.sv
tb/tb.sv
